// File: design/spimf_pkg.sv
// ----------------------------------------------------------------------------
// spimf_pkg
// Shared constants and a word-length mask function for the SPI master with transmit/receive FIFOs.
// ----------------------------------------------------------------------------
package spimf_pkg;

  // bus functions
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  // register indexes
  localparam logic [2:0] REG_RX     = 3'd0;
  localparam logic [2:0] REG_TX     = 3'd1;
  localparam logic [2:0] REG_CTRL   = 3'd2;
  localparam logic [2:0] REG_STATUS = 3'd5;

  // control bits
  localparam int CTL_ENABLE_BIT = 0;
  localparam int CTL_MASTER_BIT = 1;
  localparam int CTL_XCH_BIT    = 2;
  localparam int CTL_CPOL_BIT   = 4;
  localparam int CTL_PHA_BIT    = 5;
  localparam int CTL_SPOL_BIT   = 7;

  localparam logic [4:0] LEN_FIELD_MASK = 5'h1f;
  localparam logic [2:0] EXP_FIELD_MASK = 3'h3 | 3'h4;

  // status bits
  localparam int STS_TX_EMPTY_BIT = 0;
  localparam int STS_TX_FULL_BIT  = 2;
  localparam int STS_RX_READY_BIT = 3;

  // word length mask for len in 1..32
  function automatic logic [31:0] len_mask(input logic [5:0] len);
    logic [32:0] m;
    begin
      m = (33'd1 << len) - 33'd1;
      return m[31:0];
    end
  endfunction

endpackage

// File: design/spimf_fifo.sv
// ----------------------------------------------------------------------------
// spimf_fifo
// Word FIFO with registered head read, single push and pop per cycle.
// ----------------------------------------------------------------------------
module spimf_fifo #(
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     clear,
  input  logic                     push,
  input  logic [31:0]              push_data,
  input  logic                     pop,
  output logic [31:0]              head_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [31:0]   mem [DEPTH];
  logic [31:0]   head_r;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt, wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    begin
      if (p == AW'(DEPTH - 1)) return '0;
      return p + AW'(1);
    end
  endfunction

  assign head_data = head_r;
  assign count     = count_r;

  // pointer and count update
  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    count_nxt  = count_r;
    if (clear) begin
      rd_ptr_nxt = '0;
      wr_ptr_nxt = '0;
      count_nxt  = '0;
    end else begin
      if (push) wr_ptr_nxt = inc(wr_ptr_r);
      if (pop)  rd_ptr_nxt = inc(rd_ptr_r);
      if (push && !pop) count_nxt = count_r + CW'(1);
      else if (pop && !push) count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push && !clear) mem[wr_ptr_r] <= push_data;
  end

  // head word for the next cycle, bypassing a write into that slot
  always_ff @(posedge clk) begin
    if (push && !clear && (wr_ptr_r == rd_ptr_nxt)) head_r <= push_data;
    else head_r <= mem[rd_ptr_nxt];
  end

endmodule

// File: design/spi_master_with_fifos_core.sv
// ----------------------------------------------------------------------------
// spi_master_with_fifos_core
// SPI master behind word registers with transmit and receive FIFOs.
// ----------------------------------------------------------------------------
// results are registered in the output register, or in the skid register while out_stall holds
// throughput: one beat per cycle while in_stall is low; the whole update runs in one register stage
// an output register with a skid stage decouples out_stall from in_stall
// reset: synchronous active low; control, counters and FIFO pointers clear,
// FIFO storage is not cleared
module spi_master_with_fifos_core #(
  parameter int FIFO_DEPTH      = 8,
  parameter int MAX_DIVIDER_EXP = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [2:0]  in_reg_index,
  input  logic [31:0] in_write_data,
  input  logic        in_miso_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_data,
  output logic        out_sclk_out,
  output logic        out_mosi_out,
  output logic [3:0]  out_select_out,
  output logic        out_busy_res
);
  import spimf_pkg::*;

  localparam int CW = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [31:0] read_data;
    logic        sclk;
    logic        mosi;
    logic [3:0]  sel;
    logic        busy;
  } res_t;

  // state
  logic [31:0] ctrl_r, ctrl_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [5:0]  bitcnt_r, bitcnt_nxt;
  logic [9:0]  div_r, div_nxt;
  logic        loaded_r, loaded_nxt;
  logic        mosi_r, mosi_nxt;

  // output stage and skid
  logic out_valid_r, skid_valid_r;
  res_t out_r, skid_r, res_nxt;
  logic accept;

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !in_stall;

  // fifos
  logic          tx_clear, tx_push, tx_pop, rx_push, rx_pop;
  logic [31:0]   tx_head, rx_head, rx_wdata;
  logic [CW-1:0] tx_count, rx_count;

  spimf_fifo #(.DEPTH(FIFO_DEPTH)) u_tx (
    .clk(clk), .rst_n(rst_n), .clear(tx_clear), .push(tx_push),
    .push_data(in_write_data), .pop(tx_pop), .head_data(tx_head), .count(tx_count)
  );
  spimf_fifo #(.DEPTH(FIFO_DEPTH)) u_rx (
    .clk(clk), .rst_n(rst_n), .clear(tx_clear), .push(rx_push),
    .push_data(rx_wdata), .pop(rx_pop), .head_data(rx_head), .count(rx_count)
  );

  logic       tx_full, rx_full;
  logic [5:0] len;
  logic [4:0] msb;
  logic [31:0] lmask;
  logic [2:0] dexp;
  logic [9:0] period, half;
  logic       ld;
  logic [31:0] shw;
  logic [31:0] rd_nxt;

  assign tx_full = (tx_count == CW'(FIFO_DEPTH));
  assign rx_full = (rx_count == CW'(FIFO_DEPTH));

  // next-state logic for one beat
  always_comb begin
    ctrl_nxt   = ctrl_r;
    shift_nxt  = shift_r;
    bitcnt_nxt = bitcnt_r;
    div_nxt    = div_r;
    loaded_nxt = loaded_r;
    mosi_nxt   = mosi_r;
    tx_clear   = 1'b0;
    tx_push    = 1'b0;
    tx_pop     = 1'b0;
    rx_push    = 1'b0;
    rx_pop     = 1'b0;
    rx_wdata   = '0;
    rd_nxt     = '0;
    msb    = ctrl_r[24:20] & LEN_FIELD_MASK;
    len    = {1'b0, msb} + 6'd1;
    lmask  = len_mask(len);
    dexp   = ctrl_r[18:16] & EXP_FIELD_MASK;
    if (32'(dexp) > 32'(MAX_DIVIDER_EXP)) dexp = 3'(MAX_DIVIDER_EXP);
    period = 10'd4 << dexp;
    half   = period >> 1;
    ld     = loaded_r;
    shw    = shift_r;
    if (accept) begin
      unique case (in_func)
        FUNC_READ: begin
          if (in_reg_index == REG_RX) begin
            if (rx_count != '0) begin
              rd_nxt = rx_head;
              rx_pop = 1'b1;
            end
          end else if (in_reg_index == REG_CTRL) begin
            rd_nxt = ctrl_r;
          end else if (in_reg_index == REG_STATUS) begin
            rd_nxt[STS_TX_EMPTY_BIT] = (tx_count == '0);
            rd_nxt[STS_TX_FULL_BIT]  = tx_full;
            rd_nxt[STS_RX_READY_BIT] = (rx_count != '0);
          end
        end
        FUNC_WRITE: begin
          if (in_reg_index == REG_TX) begin
            tx_push = !tx_full;
          end else if (in_reg_index == REG_CTRL) begin
            ctrl_nxt = in_write_data;
            if (!in_write_data[CTL_ENABLE_BIT] || !in_write_data[CTL_MASTER_BIT]) begin
              tx_clear   = !in_write_data[CTL_ENABLE_BIT];
              loaded_nxt = 1'b0;
              bitcnt_nxt = '0;
              div_nxt    = '0;
              mosi_nxt   = 1'b0;
              ctrl_nxt[CTL_XCH_BIT] = 1'b0;
            end else begin
              ctrl_nxt[CTL_XCH_BIT] = in_write_data[CTL_XCH_BIT] | ctrl_r[CTL_XCH_BIT];
            end
          end
        end
        FUNC_TICK: begin
          if (ctrl_r[CTL_XCH_BIT]) begin
            if (loaded_r) begin
              div_nxt = div_r + 10'd1;
              if (div_nxt == half) shw = ((shift_r << 1) | 32'(in_miso_in)) & lmask;
              shift_nxt = shw;
              if (div_nxt >= period) begin
                div_nxt    = '0;
                bitcnt_nxt = bitcnt_r + 6'd1;
                if (bitcnt_nxt >= len) begin
                  rx_push  = !rx_full;
                  rx_wdata = shw & lmask;
                  ld       = 1'b0;
                  mosi_nxt = 1'b0;
                end else begin
                  mosi_nxt = shw[msb];
                end
              end
            end
            loaded_nxt = ld;
            if (!ld) begin
              if (tx_count != '0) begin
                shift_nxt  = tx_head & lmask;
                tx_pop     = 1'b1;
                bitcnt_nxt = '0;
                div_nxt    = '0;
                loaded_nxt = 1'b1;
                mosi_nxt   = shift_nxt[msb];
              end else begin
                loaded_nxt = 1'b0;
                bitcnt_nxt = '0;
                div_nxt    = '0;
                mosi_nxt   = 1'b0;
                ctrl_nxt[CTL_XCH_BIT] = 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // line levels from the updated state
  logic [2:0] oexp;
  logic [9:0] ohalf;
  logic       active;
  logic [3:0] sel;
  always_comb begin
    oexp = ctrl_nxt[18:16] & EXP_FIELD_MASK;
    if (32'(oexp) > 32'(MAX_DIVIDER_EXP)) oexp = 3'(MAX_DIVIDER_EXP);
    ohalf  = 10'd2 << oexp;
    active = loaded_nxt && ((div_nxt >= ohalf) ^ ctrl_nxt[CTL_PHA_BIT]);
    sel    = ctrl_nxt[CTL_SPOL_BIT] ? 4'h0 : 4'hf;
    if (ctrl_nxt[CTL_XCH_BIT]) sel = sel ^ (4'd1 << ctrl_nxt[13:12]);
    res_nxt.read_data = rd_nxt;
    res_nxt.sclk = ~ctrl_nxt[CTL_CPOL_BIT] ^ active;
    res_nxt.mosi = loaded_nxt & mosi_nxt;
    res_nxt.sel  = sel;
    res_nxt.busy = ctrl_nxt[CTL_XCH_BIT];
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r   <= '0;
      shift_r  <= '0;
      bitcnt_r <= '0;
      div_r    <= '0;
      loaded_r <= 1'b0;
      mosi_r   <= 1'b0;
    end else begin
      ctrl_r   <= ctrl_nxt;
      shift_r  <= shift_nxt;
      bitcnt_r <= bitcnt_nxt;
      div_r    <= div_nxt;
      loaded_r <= loaded_nxt;
      mosi_r   <= mosi_nxt;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || !out_stall) begin
        out_valid_r  <= skid_valid_r || accept;
        skid_valid_r <= 1'b0;
      end else if (accept) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_r <= skid_valid_r ? skid_r : res_nxt;
    end else if (accept) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = out_r.read_data;
  assign out_sclk_out   = out_r.sclk;
  assign out_mosi_out   = out_r.mosi;
  assign out_select_out = out_r.sel;
  assign out_busy_res   = out_r.busy;

  // checks
  a_skid_only_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r) else $error("skid full with output empty");
  a_no_mosi_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !loaded_r |-> !mosi_r) else $error("mosi driven with no word");
  a_loaded_busy: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_r |-> ctrl_r[CTL_XCH_BIT]) else $error("word loaded while not exchanging");
  a_tx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tx_count <= CW'(FIFO_DEPTH)) else $error("tx count overflow");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the SPI master core: drives bus reads, writes and
// serial ticks, predicts every result beat and compares all output fields.
// ----------------------------------------------------------------------------
module tb;
  import spimf_pkg::*;

  localparam int DEPTH = 8;
  localparam int MAXEXP = 7;
  localparam int N_RANDOM = 1300;
  localparam int WATCHDOG = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = FUNC_READ;
  logic [2:0]  in_reg_index = REG_RX;
  logic [31:0] in_write_data = '0;
  logic        in_miso_in = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_read_data;
  logic        out_sclk_out;
  logic        out_mosi_out;
  logic [3:0]  out_select_out;
  logic        out_busy_res;

  spi_master_with_fifos_core dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  typedef struct packed {
    logic [31:0] rd;
    logic        sclk;
    logic        mosi;
    logic [3:0]  sel;
    logic        busy;
  } line_state_t;

  // predictor state
  logic [31:0] p_ctl;
  logic [31:0] p_txq [DEPTH];
  logic [31:0] p_rxq [DEPTH];
  int          p_tx_head, p_tx_cnt, p_rx_head, p_rx_cnt;
  logic [31:0] p_shift;
  int          p_bits, p_div;
  logic        p_loaded, p_mosi;

  line_state_t expected_beats[$];
  int          n_errors = 0;
  bit          quiet_phase = 0;
  bit          hold_off = 0;
  bit          stim_done = 0;
  int          idle_cycles = 0;

  function automatic int word_len();
    return int'(p_ctl[24:20]) + 1;
  endfunction

  function automatic logic [31:0] mask_of(int len);
    return len >= 32 ? 32'hffff_ffff : (32'h1 << len) - 32'h1;
  endfunction

  function automatic int div_exp();
    int e;
    e = int'(p_ctl[18:16]);
    return e > MAXEXP ? MAXEXP : e;
  endfunction

  function automatic void stop_shifter();
    p_loaded = 0; p_bits = 0; p_div = 0; p_mosi = 0;
    p_ctl[CTL_XCH_BIT] = 1'b0;
  endfunction

  function automatic void spi_tick(logic miso);
    int len, period, half;
    if (!p_ctl[CTL_XCH_BIT]) return;
    len = word_len();
    period = 4 << div_exp();
    half = period >> 1;
    if (p_loaded) begin
      p_div++;
      if (p_div == half) p_shift = ((p_shift << 1) | miso) & mask_of(len);
      if (p_div >= period) begin
        p_div = 0;
        p_bits = (p_bits + 1) & 63;
        if (p_bits >= len) begin
          if (p_rx_cnt < DEPTH) begin
            p_rxq[(p_rx_head + p_rx_cnt) % DEPTH] = p_shift & mask_of(len);
            p_rx_cnt++;
          end
          p_loaded = 0;
          p_mosi = 0;
        end else begin
          p_mosi = p_shift[len-1];
        end
      end
    end
    if (!p_loaded) begin
      if (p_tx_cnt > 0) begin
        p_shift = p_txq[p_tx_head] & mask_of(len);
        p_tx_head = (p_tx_head + 1) % DEPTH;
        p_tx_cnt--;
        p_bits = 0; p_div = 0; p_loaded = 1;
        p_mosi = p_shift[len-1];
      end else begin
        stop_shifter();
      end
    end
  endfunction

  // compute the line state after one beat
  function automatic line_state_t spi_predict(logic [1:0] f, logic [2:0] idx,
                                              logic [31:0] d, logic miso);
    line_state_t r;
    logic running, act;
    r = '0;
    if (f == FUNC_READ) begin
      if (idx == REG_RX) begin
        if (p_rx_cnt > 0) begin
          r.rd = p_rxq[p_rx_head];
          p_rx_head = (p_rx_head + 1) % DEPTH;
          p_rx_cnt--;
        end
      end else if (idx == REG_CTRL) begin
        r.rd = p_ctl;
      end else if (idx == REG_STATUS) begin
        r.rd[STS_TX_EMPTY_BIT] = (p_tx_cnt == 0);
        r.rd[STS_TX_FULL_BIT] = (p_tx_cnt >= DEPTH);
        r.rd[STS_RX_READY_BIT] = (p_rx_cnt > 0);
      end
    end else if (f == FUNC_WRITE) begin
      if (idx == REG_TX) begin
        if (p_tx_cnt < DEPTH) begin
          p_txq[(p_tx_head + p_tx_cnt) % DEPTH] = d;
          p_tx_cnt++;
        end
      end else if (idx == REG_CTRL) begin
        running = p_ctl[CTL_XCH_BIT];
        p_ctl = d;
        if (!d[CTL_ENABLE_BIT]) begin
          p_tx_head = 0; p_tx_cnt = 0; p_rx_head = 0; p_rx_cnt = 0;
          stop_shifter();
        end else if (!d[CTL_MASTER_BIT]) begin
          stop_shifter();
        end else begin
          p_ctl[CTL_XCH_BIT] = p_ctl[CTL_XCH_BIT] | running;
        end
      end
    end else if (f == FUNC_TICK) begin
      spi_tick(miso);
    end
    r.busy = p_ctl[CTL_XCH_BIT];
    act = 1'b0;
    if (p_loaded) act = (p_div >= (2 << div_exp())) ^ p_ctl[CTL_PHA_BIT];
    r.sclk = ~p_ctl[CTL_CPOL_BIT] ^ act;
    r.mosi = p_loaded ? p_mosi : 1'b0;
    r.sel = p_ctl[CTL_SPOL_BIT] ? 4'h0 : 4'hf;
    if (r.busy) r.sel[p_ctl[13:12]] = ~r.sel[p_ctl[13:12]];
    return r;
  endfunction

  // send one beat; waits for acceptance
  task automatic send_beat(logic [1:0] f, logic [2:0] idx, logic [31:0] d, logic miso);
    int gap;
    if (!quiet_phase && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_reg_index <= idx;
    in_write_data <= d;
    in_miso_in <= miso;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_beats.push_back(spi_predict(f, idx, d, miso));
  endtask

  task automatic drain_idle();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // compose a random control word, mostly enabled master
  function automatic logic [31:0] rand_ctl(bit go);
    logic [31:0] c;
    c = $urandom;
    c[CTL_ENABLE_BIT] = ($urandom_range(0, 15) != 0);
    c[CTL_MASTER_BIT] = ($urandom_range(0, 15) != 0);
    c[CTL_XCH_BIT] = go;
    c[18:16] = $urandom_range(0, 3) == 0 ? 3'($urandom) : 3'($urandom_range(0, 1));
    c[24:20] = $urandom_range(0, 3) == 0 ? 5'($urandom) : 5'($urandom_range(0, 7));
    return c;
  endfunction

  // directed table: func, index, data, miso, check_rd, rd
  typedef struct {
    logic [1:0]  f;
    logic [2:0]  idx;
    logic [31:0] d;
    logic        miso;
    bit          chk;
    logic [31:0] rd;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{FUNC_READ,  REG_STATUS, 32'h0, 1'b0, 1, 32'h1},
    '{FUNC_READ,  REG_RX,     32'h0, 1'b0, 1, 32'h0},
    '{FUNC_READ,  REG_CTRL,   32'h0, 1'b0, 1, 32'h0},
    '{FUNC_READ,  3'd3,       32'h0, 1'b0, 1, 32'h0},
    '{FUNC_WRITE, 3'd7,       32'hffff_ffff, 1'b0, 0, 32'h0},
    '{FUNC_READ,  3'd7,       32'h0, 1'b0, 1, 32'h0},
    '{FUNC_WRITE, REG_TX,     32'hffff_ffff, 1'b0, 0, 32'h0},
    '{FUNC_WRITE, REG_TX,     32'h0, 1'b0, 0, 32'h0},
    '{FUNC_WRITE, REG_CTRL,   32'h0070_1097, 1'b0, 0, 32'h0},
    '{FUNC_TICK,  REG_RX,     32'h0, 1'b1, 0, 32'h0},
    '{FUNC_TICK,  REG_RX,     32'h0, 1'b1, 0, 32'h0},
    '{2'd3,       REG_RX,     32'h0, 1'b1, 0, 32'h0},
    '{FUNC_TICK,  REG_RX,     32'h0, 1'b0, 0, 32'h0},
    '{FUNC_WRITE, REG_CTRL,   32'h01f7_30b3, 1'b0, 0, 32'h0},
    '{FUNC_WRITE, REG_CTRL,   32'hffff_fffd, 1'b0, 0, 32'h0},
    '{FUNC_WRITE, REG_CTRL,   32'h0, 1'b0, 0, 32'h0},
    '{FUNC_READ,  REG_CTRL,   32'h0, 1'b0, 1, 32'h0}
  };

  // stimulus
  initial begin
    int nwords, nticks;
    p_ctl = '0; p_tx_head = 0; p_tx_cnt = 0; p_rx_head = 0; p_rx_cnt = 0;
    p_shift = '0; p_bits = 0; p_div = 0; p_loaded = 0; p_mosi = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].f, dir_rows[i].idx, dir_rows[i].d, dir_rows[i].miso);
      if (dir_rows[i].chk && expected_beats[$].rd !== dir_rows[i].rd) begin
        n_errors++;
        $display("table row %0d: read %h expected %h", i, expected_beats[$].rd,
                 dir_rows[i].rd);
      end
    end
    // fill tx to overflow then long exchange while the receiver holds off
    send_beat(FUNC_WRITE, REG_CTRL, 32'h0000_0003, 1'b0);
    for (int i = 0; i < DEPTH + 2; i++) send_beat(FUNC_WRITE, REG_TX, $urandom, 1'b0);
    send_beat(FUNC_READ, REG_STATUS, 32'h0, 1'b0);
    send_beat(FUNC_WRITE, REG_CTRL, 32'h0010_0007, 1'b0);
    hold_off = 1;
    for (int i = 0; i < 40; i++) send_beat(FUNC_TICK, REG_RX, 32'h0, 1'($urandom));
    for (int i = 0; i < 8; i++) send_beat(FUNC_READ, REG_RX, 32'h0, 1'b0);
    drain_idle();
    // random exchanges
    for (int n = 0; n < N_RANDOM; ) begin
      if (n > N_RANDOM * 4 / 5) quiet_phase = 1;
      send_beat(FUNC_WRITE, REG_CTRL, rand_ctl(0), 1'b0); n++;
      nwords = $urandom_range(0, 3);
      for (int w = 0; w < nwords; w++) begin
        send_beat(FUNC_WRITE, REG_TX, $urandom, 1'b0); n++;
      end
      send_beat(FUNC_WRITE, REG_CTRL, rand_ctl(1), 1'b0); n++;
      nticks = $urandom_range(5, 60);
      for (int t = 0; t < nticks; t++) begin
        case ($urandom_range(0, 11))
          0: send_beat(FUNC_READ, 3'($urandom), 32'h0, 1'b0);
          1: send_beat(FUNC_WRITE, 3'($urandom), $urandom, 1'($urandom));
          2: send_beat(2'($urandom), 3'($urandom), $urandom, 1'($urandom));
          default: send_beat(FUNC_TICK, 3'($urandom), $urandom, 1'($urandom));
        endcase
        n++;
      end
      for (int r = 0; r < 3; r++) begin
        send_beat(FUNC_READ, $urandom_range(0, 1) ? REG_RX : REG_STATUS, 32'h0, 1'b0); n++;
      end
    end
    in_valid <= 1'b0;
    stim_done = 1;
  end

  // receiver idling and one long hold-off
  initial begin
    int burst;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        hold_off = 0;
        out_stall <= 1'b1;
        repeat (60) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 7);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    line_state_t e, got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_read_data, out_sclk_out, out_mosi_out, out_select_out, out_busy_res};
      if (expected_beats.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result beat %p", got);
      end else begin
        e = expected_beats.pop_front();
        if (got !== e) begin
          n_errors++;
          if (n_errors <= 10) $display("mismatch: expected %p actual %p", e, got);
        end
      end
    end
  end

  // watchdog and end of run
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_errors == 0 && expected_beats.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: spi_master_with_fifos_core.f
design/spimf_pkg.sv
design/spimf_fifo.sv
design/spi_master_with_fifos_core.sv
test/tb.sv
